// ===== hdl/x86rel_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and relocation type codes for the x86-64 relocation unit.
package x86rel_pkg;

  localparam logic [31:0] R_NONE     = 32'd0;
  localparam logic [31:0] R_64       = 32'd1;
  localparam logic [31:0] R_PC32     = 32'd2;
  localparam logic [31:0] R_PLT32    = 32'd4;
  localparam logic [31:0] R_32       = 32'd10;
  localparam logic [31:0] R_32S      = 32'd11;
  localparam logic [31:0] R_16       = 32'd12;
  localparam logic [31:0] R_PC16     = 32'd13;
  localparam logic [31:0] R_8        = 32'd14;
  localparam logic [31:0] R_PC8      = 32'd15;
  localparam logic [31:0] R_PC64     = 32'd24;
  localparam logic [31:0] R_SIZE32   = 32'd32;
  localparam logic [31:0] R_SIZE64   = 32'd33;

  localparam int WideBits = 66;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_RAW64,
    KIND_CHECKED,
    KIND_UNKNOWN
  } reloc_kind_t;

  typedef enum logic [1:0] {
    WIDTH_8,
    WIDTH_16,
    WIDTH_32,
    WIDTH_64
  } store_width_t;

  typedef struct packed {
    reloc_kind_t  kind;
    logic         use_relative;
    logic         is_signed;
    store_width_t width;
  } reloc_ctrl_t;

  typedef struct packed {
    logic [63:0] store_value;
    logic [3:0]  store_bytes;
    logic        status;
  } reloc_result_t;

endpackage

// ===== hdl/x86_64_relocation_unit_top.sv =====
`timescale 1ns / 1ps
// Top level of the x86-64 relocation unit: input register, compute logic, result register.
// Flow: the input register holds an accepted transaction, then the result register holds its result.
// Throughput: one transaction per cycle while out_stall is low, set by the add, subtract and
// check path between the input register and the result register.
// Reset: rst clears both valid flags; payload registers are not reset.
module x86_64_relocation_unit_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        reloc_type,
  input  logic [63:0]        sym_value,
  input  logic signed [63:0] reloc_addend,
  input  logic [63:0]        place_address,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        store_value,
  output logic [3:0]         store_bytes,
  output logic               status
);

  logic                      s1_valid;
  logic [31:0]               s1_type;
  logic [63:0]               s1_symbol;
  logic signed [63:0]        s1_addend;
  logic [63:0]               s1_place;
  logic                      s2_valid;
  x86rel_pkg::reloc_result_t s2_result;

  x86rel_pkg::reloc_ctrl_t   ctrl;
  x86rel_pkg::reloc_result_t result;
  logic                      s2_load;
  logic                      s1_load;

  assign s2_load  = !s2_valid || !out_stall;
  assign s1_load  = !s1_valid || s2_load;
  assign in_stall = !s1_load;

  x86rel_decode u_decode (
    .reloc_type (s1_type),
    .ctrl       (ctrl)
  );

  x86rel_compute u_compute (
    .ctrl          (ctrl),
    .sym_value     (s1_symbol),
    .reloc_addend  (s1_addend),
    .place_address (s1_place),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= in_valid;
      end
      if (s2_load) begin
        s2_valid <= s1_valid;
      end
    end
    if (s1_load && in_valid) begin
      s1_type   <= reloc_type;
      s1_symbol <= sym_value;
      s1_addend <= reloc_addend;
      s1_place  <= place_address;
    end
    if (s2_load && s1_valid) begin
      s2_result <= result;
    end
  end

  assign out_valid   = s2_valid;
  assign store_value = s2_result.store_value;
  assign store_bytes = s2_result.store_bytes;
  assign status      = s2_result.status;

  a_reject_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (store_bytes == 4'd0 && store_value == 64'd0))
    else $error("Rejected transaction carries a store.");

  a_bytes_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (store_bytes == 4'd0 || store_bytes == 4'd1 || store_bytes == 4'd2 ||
                   store_bytes == 4'd4 || store_bytes == 4'd8))
    else $error("Illegal store width.");

  a_value_masked: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (store_bytes == 4'd1 || store_bytes == 4'd2 || store_bytes == 4'd4)) |->
      (store_value[63:32] == 32'd0))
    else $error("Narrow store has high bits set.");

  a_stage1_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && in_stall) |=> (s1_valid && $stable(s1_type) && $stable(s1_symbol)))
    else $error("Input register lost a transaction while stalled.");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s2_valid && out_stall))
    else $error("Input stalled with room in the pipeline.");

endmodule

// ===== hdl/x86rel_decode.sv =====
`timescale 1ns / 1ps
// Relocation type decoder: selects value source, check kind, signedness and store width.
module x86rel_decode (
  input  logic [31:0]             reloc_type,
  output x86rel_pkg::reloc_ctrl_t ctrl
);

  always_comb begin
    ctrl.kind         = x86rel_pkg::KIND_CHECKED;
    ctrl.use_relative = 1'b0;
    ctrl.is_signed    = 1'b1;
    ctrl.width        = x86rel_pkg::WIDTH_32;
    unique case (reloc_type) inside
      x86rel_pkg::R_NONE: begin
        ctrl.kind = x86rel_pkg::KIND_NONE;
      end
      x86rel_pkg::R_64, x86rel_pkg::R_SIZE64: begin
        ctrl.kind  = x86rel_pkg::KIND_RAW64;
        ctrl.width = x86rel_pkg::WIDTH_64;
      end
      x86rel_pkg::R_PC32, x86rel_pkg::R_PLT32: begin
        ctrl.use_relative = 1'b1;
      end
      x86rel_pkg::R_32, x86rel_pkg::R_32S: begin
        ctrl.width = x86rel_pkg::WIDTH_32;
      end
      x86rel_pkg::R_16: begin
        ctrl.is_signed = 1'b0;
        ctrl.width     = x86rel_pkg::WIDTH_16;
      end
      x86rel_pkg::R_PC16: begin
        ctrl.use_relative = 1'b1;
        ctrl.width        = x86rel_pkg::WIDTH_16;
      end
      x86rel_pkg::R_8: begin
        ctrl.is_signed = 1'b0;
        ctrl.width     = x86rel_pkg::WIDTH_8;
      end
      x86rel_pkg::R_PC8: begin
        ctrl.use_relative = 1'b1;
        ctrl.width        = x86rel_pkg::WIDTH_8;
      end
      x86rel_pkg::R_PC64: begin
        ctrl.use_relative = 1'b1;
        ctrl.width        = x86rel_pkg::WIDTH_64;
      end
      x86rel_pkg::R_SIZE32: begin
        ctrl.is_signed = 1'b0;
        ctrl.width     = x86rel_pkg::WIDTH_32;
      end
      default: begin
        ctrl.kind = x86rel_pkg::KIND_UNKNOWN;
      end
    endcase
  end

endmodule

// ===== hdl/x86rel_compute.sv =====
`timescale 1ns / 1ps
// Value computation, range check and store formatting for one relocation.
module x86rel_compute (
  input  x86rel_pkg::reloc_ctrl_t   ctrl,
  input  logic [63:0]               sym_value,
  input  logic signed [63:0]        reloc_addend,
  input  logic [63:0]               place_address,
  output x86rel_pkg::reloc_result_t result
);

  localparam int W = x86rel_pkg::WideBits;

  logic [W-1:0] sym_w;
  logic [W-1:0] add_w;
  logic [W-1:0] place_w;
  logic [W-1:0] abs_v;
  logic [W-1:0] rel_v;
  logic [W-1:0] v;
  logic         fits;
  logic [63:0]  masked;
  logic [3:0]   bytes;

  assign sym_w   = {{(W-64){sym_value[63]}}, sym_value};
  assign add_w   = {{(W-64){reloc_addend[63]}}, reloc_addend};
  assign place_w = {{(W-64){place_address[63]}}, place_address};
  assign abs_v   = sym_w + add_w;
  assign rel_v   = abs_v - place_w;
  assign v       = ctrl.use_relative ? rel_v : abs_v;

  always_comb begin
    fits   = 1'b0;
    masked = 64'd0;
    bytes  = 4'd0;
    case (ctrl.width)
      x86rel_pkg::WIDTH_8: begin
        fits   = ctrl.is_signed ? ((&v[W-1:7]) || !(|v[W-1:7])) : !(|v[W-1:8]);
        masked = {56'd0, v[7:0]};
        bytes  = 4'd1;
      end
      x86rel_pkg::WIDTH_16: begin
        fits   = ctrl.is_signed ? ((&v[W-1:15]) || !(|v[W-1:15])) : !(|v[W-1:16]);
        masked = {48'd0, v[15:0]};
        bytes  = 4'd2;
      end
      x86rel_pkg::WIDTH_32: begin
        fits   = ctrl.is_signed ? ((&v[W-1:31]) || !(|v[W-1:31])) : !(|v[W-1:32]);
        masked = {32'd0, v[31:0]};
        bytes  = 4'd4;
      end
      default: begin
        fits   = ctrl.is_signed ? ((&v[W-1:63]) || !(|v[W-1:63])) : !(|v[W-1:64]);
        masked = v[63:0];
        bytes  = 4'd8;
      end
    endcase
  end

  always_comb begin
    result.store_value = 64'd0;
    result.store_bytes = 4'd0;
    result.status      = 1'b0;
    case (ctrl.kind)
      x86rel_pkg::KIND_NONE: begin
        result.status = 1'b0;
      end
      x86rel_pkg::KIND_RAW64: begin
        result.store_value = abs_v[63:0];
        result.store_bytes = 4'd8;
      end
      x86rel_pkg::KIND_CHECKED: begin
        if (fits) begin
          result.store_value = masked;
          result.store_bytes = bytes;
        end else begin
          result.status = 1'b1;
        end
      end
      default: begin
        result.status = 1'b1;
      end
    endcase
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the x86-64 relocation unit: directed and random relocations.
module testbench;

  typedef struct packed {
    logic [31:0] rtype;
    logic [63:0] sym;
    logic [63:0] add;
    logic [63:0] place;
  } reloc_item_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [31:0]        reloc_type = '0;
  logic [63:0]        sym_value = '0;
  logic signed [63:0] reloc_addend = '0;
  logic [63:0]        place_address = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [63:0]        store_value;
  logic [3:0]         store_bytes;
  logic               status;

  reloc_item_t               pending_relocs[$];
  x86rel_pkg::reloc_result_t expected_patches[$];
  int                        mismatch_count = 0;
  reloc_item_t               driven_reloc = '0;
  int                        burst_left = 0;
  int                        gap_left = 0;
  int                        stall_mode = 0;
  int                        stall_mode_left = 0;
  int unsigned               cycle_count = 0;

  logic [31:0] known_types[13] = '{x86rel_pkg::R_NONE, x86rel_pkg::R_64,
                                   x86rel_pkg::R_PC32, x86rel_pkg::R_PLT32,
                                   x86rel_pkg::R_32, x86rel_pkg::R_32S,
                                   x86rel_pkg::R_16, x86rel_pkg::R_PC16,
                                   x86rel_pkg::R_8, x86rel_pkg::R_PC8,
                                   x86rel_pkg::R_PC64, x86rel_pkg::R_SIZE32,
                                   x86rel_pkg::R_SIZE64};

  x86_64_relocation_unit_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .reloc_type   (reloc_type),
    .sym_value    (sym_value),
    .reloc_addend (reloc_addend),
    .place_address(place_address),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .store_value  (store_value),
    .store_bytes  (store_bytes),
    .status       (status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic x86rel_pkg::reloc_result_t predict_patch(reloc_item_t it);
    logic [65:0]               abs_sum;
    logic [65:0]               rel_diff;
    logic [65:0]               chosen;
    logic signed [65:0]        shifted;
    int                        nbits;
    logic                      chk_signed;
    logic                      in_range;
    x86rel_pkg::reloc_result_t res;
    abs_sum    = {{2{it.sym[63]}}, it.sym} + {{2{it.add[63]}}, it.add};
    rel_diff   = abs_sum - {{2{it.place[63]}}, it.place};
    res        = '0;
    chosen     = abs_sum;
    nbits      = 64;
    chk_signed = 1'b1;
    case (it.rtype)
      x86rel_pkg::R_NONE: return res;
      x86rel_pkg::R_64, x86rel_pkg::R_SIZE64: begin
        res.store_value = it.sym + it.add;
        res.store_bytes = 4'd8;
        return res;
      end
      x86rel_pkg::R_PC32, x86rel_pkg::R_PLT32: begin
        chosen = rel_diff;
        nbits  = 32;
      end
      x86rel_pkg::R_32, x86rel_pkg::R_32S: nbits = 32;
      x86rel_pkg::R_16: begin
        nbits      = 16;
        chk_signed = 1'b0;
      end
      x86rel_pkg::R_PC16: begin
        chosen = rel_diff;
        nbits  = 16;
      end
      x86rel_pkg::R_8: begin
        nbits      = 8;
        chk_signed = 1'b0;
      end
      x86rel_pkg::R_PC8: begin
        chosen = rel_diff;
        nbits  = 8;
      end
      x86rel_pkg::R_PC64: chosen = rel_diff;
      x86rel_pkg::R_SIZE32: begin
        nbits      = 32;
        chk_signed = 1'b0;
      end
      default: begin
        res.status = 1'b1;
        return res;
      end
    endcase
    if (chk_signed) begin
      shifted  = $signed(chosen) >>> (nbits - 1);
      in_range = (shifted == '0) || (shifted == '1);
    end else begin
      in_range = ((chosen >> nbits) == '0);
    end
    if (!in_range) begin
      res.status = 1'b1;
      return res;
    end
    res.store_value = chosen[63:0] &
                      ((nbits == 64) ? {64{1'b1}} : ((64'd1 << nbits) - 64'd1));
    res.store_bytes = 4'(nbits / 8);
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic queue_reloc(logic [31:0] rtype, logic [63:0] sym, logic [63:0] add,
                             logic [63:0] place);
    reloc_item_t it;
    it.rtype = rtype;
    it.sym   = sym;
    it.add   = add;
    it.place = place;
    pending_relocs.push_back(it);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left <= $urandom_range(1, 20);
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall) expected_patches.push_back(predict_patch(driven_reloc));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_relocs.size() > 0) begin
          driven_reloc  <= pending_relocs[0];
          reloc_type    <= pending_relocs[0].rtype;
          sym_value     <= pending_relocs[0].sym;
          reloc_addend  <= pending_relocs[0].add;
          place_address <= pending_relocs[0].place;
          void'(pending_relocs.pop_front());
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left <= ($urandom_range(0, 5) == 0) ? 120 : $urandom_range(1, 20);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    x86rel_pkg::reloc_result_t want;
    cycle_count <= cycle_count + 1;
    if (rst) begin
      out_stall       <= 1'b0;
      stall_mode      <= 0;
      stall_mode_left <= 100;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_patches.size() == 0) begin
          report_mismatch("result transaction with no expected patch");
        end else begin
          want = expected_patches.pop_front();
          if (store_value !== want.store_value)
            report_mismatch($sformatf("store_value got %h want %h", store_value,
                                      want.store_value));
          if (store_bytes !== want.store_bytes)
            report_mismatch($sformatf("store_bytes got %0d want %0d", store_bytes,
                                      want.store_bytes));
          if (status !== want.status)
            report_mismatch($sformatf("status got %b want %b", status, want.status));
        end
      end
      if (stall_mode_left == 0) begin
        stall_mode      <= $urandom_range(0, 3);
        stall_mode_left <= $urandom_range(40, 200);
      end else begin
        stall_mode_left <= stall_mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 1);
        2: out_stall <= ($urandom_range(0, 99) < 85);
        default: out_stall <= (cycle_count % 3 == 0);
      endcase
    end
  end

  initial begin : stimulus
    logic [31:0] rtype;
    logic [63:0] sym;
    logic [63:0] add;
    logic [63:0] place;
    logic [63:0] target;
    logic [63:0] smax;
    logic [63:0] umax;
    logic [63:0] delta;
    int          nbits;
    logic        rel;
    int          sel;
    int          n;
    int          waited;

    queue_reloc(x86rel_pkg::R_NONE, {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
    queue_reloc(x86rel_pkg::R_64, {64{1'b1}}, 64'd1, 64'd0);
    queue_reloc(x86rel_pkg::R_SIZE64, 64'h8000_0000_0000_0000, {64{1'b1}}, 64'd5);
    queue_reloc(x86rel_pkg::R_PC32, 64'h1000, -64'sd4, 64'h2000);
    queue_reloc(x86rel_pkg::R_PLT32, 64'h7fff_ffff, 64'd0, 64'd0);
    queue_reloc(x86rel_pkg::R_PC32, 64'h8000_0000, 64'd0, 64'd0);
    queue_reloc(x86rel_pkg::R_32, 64'h7fff_ffff, 64'd0, 64'd0);
    queue_reloc(x86rel_pkg::R_32S, 64'd0, -64'sh8000_0000, 64'd0);
    queue_reloc(x86rel_pkg::R_32, 64'd0, -64'sh8000_0001, 64'd0);
    queue_reloc(x86rel_pkg::R_16, 64'hfffe, 64'd1, 64'd0);
    queue_reloc(x86rel_pkg::R_16, 64'hffff, 64'd1, 64'd0);
    queue_reloc(x86rel_pkg::R_16, 64'd0, {64{1'b1}}, 64'd0);
    queue_reloc(x86rel_pkg::R_PC16, 64'd0, 64'd0, 64'h8000);
    queue_reloc(x86rel_pkg::R_PC16, 64'h8000, 64'd0, 64'd0);
    queue_reloc(x86rel_pkg::R_8, 64'hff, 64'd0, 64'd0);
    queue_reloc(x86rel_pkg::R_8, 64'h100, 64'd0, 64'd0);
    queue_reloc(x86rel_pkg::R_PC8, 64'd0, -64'sd128, 64'd0);
    queue_reloc(x86rel_pkg::R_PC8, 64'd0, -64'sd129, 64'd0);
    queue_reloc(x86rel_pkg::R_PC64, 64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff, 64'd0);
    queue_reloc(x86rel_pkg::R_PC64, 64'h8000_0000_0000_0000, 64'd0, 64'd1);
    queue_reloc(x86rel_pkg::R_PC64, 64'd0, {64{1'b1}}, {64{1'b1}});
    queue_reloc(x86rel_pkg::R_SIZE32, 64'hffff_ffff, 64'd0, 64'd0);
    queue_reloc(x86rel_pkg::R_SIZE32, 64'hffff_ffff, 64'd1, 64'd0);
    queue_reloc(x86rel_pkg::R_SIZE32, 64'd0, {64{1'b1}}, 64'd0);
    queue_reloc(32'd3, 64'd0, 64'd0, 64'd0);
    queue_reloc(32'hffff_ffff, 64'd1, 64'd1, 64'd1);
    queue_reloc(32'h8000_0021, 64'd1, 64'd1, 64'd1);

    for (n = 0; n < 1150; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        rtype = ($urandom_range(0, 1) == 0) ? $urandom : known_types[$urandom_range(0, 12)];
        queue_reloc(rtype, rand64(), rand64(), rand64());
      end else if (sel < 25) begin
        queue_reloc(known_types[$urandom_range(0, 12)], rand64(), rand64(), rand64());
      end else begin
        rtype = known_types[$urandom_range(0, 12)];
        rel   = 1'b0;
        nbits = 64;
        case (rtype)
          x86rel_pkg::R_PC32, x86rel_pkg::R_PLT32: begin
            rel   = 1'b1;
            nbits = 32;
          end
          x86rel_pkg::R_32, x86rel_pkg::R_32S, x86rel_pkg::R_SIZE32: nbits = 32;
          x86rel_pkg::R_16: nbits = 16;
          x86rel_pkg::R_PC16: begin
            rel   = 1'b1;
            nbits = 16;
          end
          x86rel_pkg::R_8: nbits = 8;
          x86rel_pkg::R_PC8: begin
            rel   = 1'b1;
            nbits = 8;
          end
          x86rel_pkg::R_PC64: rel = 1'b1;
          default: rel = 1'b0;
        endcase
        smax = (64'd1 << (nbits - 1)) - 64'd1;
        umax = (nbits == 64) ? {64{1'b1}} : ((64'd1 << nbits) - 64'd1);
        case ($urandom_range(0, 4))
          0: target = smax;
          1: target = ~smax;
          2: target = umax;
          3: target = 64'd0;
          default: target = rand64() & smax;
        endcase
        delta  = {61'd0, 3'($urandom_range(0, 6))} - 64'd3;
        target = target + delta;
        sym    = ($urandom_range(0, 1) == 0) ? rand64() : {{32{1'b0}}, $urandom};
        if ($urandom_range(0, 1) == 0) sym = {{32{sym[31]}}, sym[31:0]};
        place  = rand64();
        if ($urandom_range(0, 2) != 0) place = {{32{place[31]}}, place[31:0]};
        add    = target - sym + (rel ? place : 64'd0);
        queue_reloc(rtype, sym, add, place);
      end
    end

    @(posedge clk);
    while (rst) @(posedge clk);
    while (pending_relocs.size() > 0 || in_valid) @(posedge clk);
    waited = 0;
    while (expected_patches.size() > 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (expected_patches.size() > 0)
      report_mismatch($sformatf("%0d expected patches never arrived",
                                expected_patches.size()));
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
